// ----- rtl/core/linear_delta_inverse_kinematics_core_assert.svh -----
// Assertion macros shared by the delta kinematics core modules.
// Needs a clock and a synchronous active-high reset at each use.
`ifndef LINEAR_DELTA_INVERSE_KINEMATICS_CORE_ASSERT_SVH
`define LINEAR_DELTA_INVERSE_KINEMATICS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDIK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ldik: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LDIK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ldik: next-cycle check failed");

`endif

// ----- rtl/core/ldik_pkg.sv -----
// Shared types and constants for the delta kinematics core.
// No dependencies; the module files refer to it by scoped names.
package ldik_pkg;

  localparam int REG_BITS   = 18;
  localparam int OUT_BITS   = 21;
  localparam int SQRT3_BITS = 21;
  localparam int ROUND_SHIFT = 20;
  localparam int MAG_BITS   = REG_BITS + 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int ROOT_BITS  = MAG_BITS;
  localparam int LANES      = 3;
  localparam int IDX_BITS   = 2;

  // sqrt(3) in Q20, rounded to nearest.
  localparam logic [SQRT3_BITS-1:0] SQRT3_Q20 = 21'd1816187;

  localparam logic [IDX_BITS-1:0] REG_ARM_LENGTH      = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_PLATFORM_RADIUS = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_BASE_RADIUS     = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_CARRIAGE_OFFSET = 2'd3;

  localparam logic [REG_BITS-1:0] ARM_LENGTH_RST      = 18'd225000;
  localparam logic [REG_BITS-1:0] PLATFORM_RADIUS_RST = 18'd60000;
  localparam logic [REG_BITS-1:0] BASE_RADIUS_RST     = 18'd170000;
  localparam logic [REG_BITS-1:0] CARRIAGE_OFFSET_RST = 18'd196000;

  typedef struct packed {
    logic [REG_BITS-1:0] arm_length;
    logic [REG_BITS-1:0] platform_radius;
    logic [REG_BITS-1:0] base_radius;
    logic [REG_BITS-1:0] carriage_offset;
  } cfg_t;

endpackage

// ----- rtl/core/ldik_geom.sv -----
// Geometry front end: tower offsets, horizontal distances, squares and radicands.
// Five register stages; uses ldik_pkg.
module ldik_geom #(
  parameter int COORD_BITS = 19
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  ldik_pkg::cfg_t                                cfg,
  input  logic                                          in_valid,
  input  logic signed [COORD_BITS-1:0]                  x,
  input  logic signed [COORD_BITS-1:0]                  y,
  input  logic signed [COORD_BITS-1:0]                  z,
  output logic                                          rad_valid,
  output logic [ldik_pkg::LANES-1:0][ldik_pkg::SQ_BITS-1:0] rad,
  output logic signed [COORD_BITS-1:0]                  rad_z,
  output logic                                          rad_fail
);

  localparam int RB = ldik_pkg::REG_BITS;
  localparam int PW = ldik_pkg::REG_BITS + ldik_pkg::SQRT3_BITS;
  localparam int HB = ldik_pkg::MAG_BITS + 1;
  localparam int DW = ((COORD_BITS + 1 > HB) ? COORD_BITS + 1 : HB) + 1;
  localparam int MB = ldik_pkg::MAG_BITS;
  localparam int SB = ldik_pkg::SQ_BITS;
  localparam int EB = ldik_pkg::SQ_BITS + 2;

  // Stage 1: capture and sqrt(3) * |delta|.
  logic                         v1;
  logic signed [COORD_BITS-1:0] x1, y1, z1;
  logic [PW-1:0]                prod1;
  logic [RB:0]                  delta1;
  logic [RB:0]                  delta_c;
  logic [RB-1:0]                dmag_c;
  logic [RB:0]                  delta_neg_c;

  assign delta_c     = {1'b0, cfg.platform_radius} - {1'b0, cfg.base_radius};
  assign delta_neg_c = -delta_c;
  assign dmag_c      = delta_c[RB] ? delta_neg_c[RB-1:0] : delta_c[RB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1     <= x;
      y1     <= y;
      z1     <= z;
      prod1  <= PW'(dmag_c) * PW'(ldik_pkg::SQRT3_Q20);
      delta1 <= delta_c;
    end
  end

  // Stage 2: per-tower distances in half micrometres.
  logic                         v2;
  logic signed [COORD_BITS-1:0] z2;
  logic [DW-1:0]                dx1_2, dy1_2, dx2_2, dy2_2, dx3_2;
  logic [PW-1:0]                prod_rnd;
  logic [MB-1:0]                hmag;
  logic [HB-1:0]                h_c;
  logic [DW-1:0]                x_e, y_e, h_e, d_e, x2_c, y2_c, d2_c;

  assign prod_rnd = prod1 + (PW'(1) << (ldik_pkg::ROUND_SHIFT - 1));
  assign hmag     = prod_rnd[ldik_pkg::ROUND_SHIFT +: MB];
  assign h_c      = delta1[RB] ? -{1'b0, hmag} : {1'b0, hmag};
  assign x_e      = {{(DW-COORD_BITS){x1[COORD_BITS-1]}}, x1};
  assign y_e      = {{(DW-COORD_BITS){y1[COORD_BITS-1]}}, y1};
  assign h_e      = {{(DW-HB){h_c[HB-1]}}, h_c};
  assign d_e      = {{(DW-RB-1){delta1[RB]}}, delta1};
  assign x2_c     = {x_e[DW-2:0], 1'b0};
  assign y2_c     = {y_e[DW-2:0], 1'b0};
  assign d2_c     = {d_e[DW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z2    <= z1;
      dx1_2 <= x2_c;
      dy1_2 <= y2_c + d2_c;
      dx2_2 <= x2_c - h_e;
      dy2_2 <= y2_c - d_e;
      dx3_2 <= x2_c + h_e;
    end
  end

  // Stage 3: magnitudes and reach check against 2L.
  logic                         v3, fail3;
  logic signed [COORD_BITS-1:0] z3;
  logic [4:0][MB-1:0]           mag3;
  logic [4:0][DW-1:0]           dist_c, abs_c;
  logic [4:0]                   over_c;
  logic [DW-1:0]                two_l_e;

  assign dist_c  = {dx3_2, dy2_2, dx2_2, dy1_2, dx1_2};
  assign two_l_e = {{(DW-MB){1'b0}}, cfg.arm_length, 1'b0};

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      abs_c[i]  = dist_c[i][DW-1] ? -dist_c[i] : dist_c[i];
      over_c[i] = abs_c[i] > two_l_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z3    <= z2;
      fail3 <= |over_c;
      for (int i = 0; i < 5; i++) begin
        mag3[i] <= abs_c[i][MB-1:0];
      end
    end
  end

  // Stage 4: squares.
  logic                         v4, fail4;
  logic signed [COORD_BITS-1:0] z4;
  logic [4:0][SB-1:0]           sq4;
  logic [SB-1:0]                ll4;
  logic [MB-1:0]                two_l;

  assign two_l = {cfg.arm_length, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z4    <= z3;
      fail4 <= fail3;
      ll4   <= SB'(two_l) * SB'(two_l);
      for (int i = 0; i < 5; i++) begin
        sq4[i] <= SB'(mag3[i]) * SB'(mag3[i]);
      end
    end
  end

  // Stage 5: radicands (four times the true radicand).
  logic [ldik_pkg::LANES-1:0][EB-1:0] s_c;
  logic [ldik_pkg::LANES-1:0]         neg_c;

  // Lane order of sq4: dx1, dy1, dx2, dy2 (shared by towers two and three), dx3.
  assign s_c[0] = {2'b00, ll4} - {2'b00, sq4[0]} - {2'b00, sq4[1]};
  assign s_c[1] = {2'b00, ll4} - {2'b00, sq4[2]} - {2'b00, sq4[3]};
  assign s_c[2] = {2'b00, ll4} - {2'b00, sq4[4]} - {2'b00, sq4[3]};

  always_comb begin
    for (int i = 0; i < ldik_pkg::LANES; i++) begin
      neg_c[i] = s_c[i][EB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_valid <= 1'b0;
    end else if (en) begin
      rad_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_z    <= z4;
      rad_fail <= fail4 | (|neg_c);
      for (int i = 0; i < ldik_pkg::LANES; i++) begin
        rad[i] <= s_c[i][SB-1:0];
      end
    end
  end

endmodule

// ----- rtl/core/ldik_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, three lanes side by side.
// A tag rides along with each beat; uses ldik_pkg and the assertion header.
`include "linear_delta_inverse_kinematics_core_assert.svh"

module ldik_isqrt #(
  parameter int TAG_BITS = 20
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                en,
  input  logic                                                in_valid,
  input  logic [ldik_pkg::LANES-1:0][ldik_pkg::SQ_BITS-1:0]   rad,
  input  logic [TAG_BITS-1:0]                                 tag_in,
  output logic                                                out_valid,
  output logic [ldik_pkg::LANES-1:0][ldik_pkg::ROOT_BITS-1:0] root,
  output logic [TAG_BITS-1:0]                                 tag_out
);

  localparam int NS = ldik_pkg::ROOT_BITS;
  localparam int RT = ldik_pkg::ROOT_BITS;
  localparam int SB = ldik_pkg::SQ_BITS;
  localparam int RW = RT + 3;
  localparam int NL = ldik_pkg::LANES;

  logic [NS-1:0]                 v_q;
  logic [NL-1:0][RW-1:0]         rem_q  [NS];
  logic [NL-1:0][RT-1:0]         root_q [NS];
  logic [NL-1:0][SB-1:0]         n_q    [NS];
  logic [TAG_BITS-1:0]           tag_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                   v_i;
    logic [NL-1:0][RW-1:0]  rem_i;
    logic [NL-1:0][RT-1:0]  root_i;
    logic [NL-1:0][SB-1:0]  n_i;
    logic [TAG_BITS-1:0]    tag_i;
    logic [NL-1:0][RW-1:0]  rem_n;
    logic [NL-1:0][RT-1:0]  root_n;
    logic [NL-1:0][SB-1:0]  n_n;

    if (k == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = rad;
      assign tag_i  = tag_in;
    end else begin : g_body
      assign v_i    = v_q[k-1];
      assign rem_i  = rem_q[k-1];
      assign root_i = root_q[k-1];
      assign n_i    = n_q[k-1];
      assign tag_i  = tag_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1 against them.
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [RW-1:0] cat;
      logic [RW-1:0] trial;
      logic          ge;

      assign cat         = {rem_i[l][RW-3:0], n_i[l][SB-1 -: 2]};
      assign trial       = {1'b0, root_i[l], 2'b01};
      assign ge          = cat >= trial;
      assign rem_n[l]    = ge ? cat - trial : cat;
      assign root_n[l]   = {root_i[l][RT-2:0], ge};
      assign n_n[l]      = {n_i[l][SB-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= rem_n;
        root_q[k] <= root_n;
        n_q[k]    <= n_n;
        tag_q[k]  <= tag_i;
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign root      = root_q[NS-1];
  assign tag_out   = tag_q[NS-1];

  `LDIK_ASSERT_NEXT(a_frozen_when_held, clk, rst, !en, $stable(v_q))
  `LDIK_ASSERT_NEXT(a_valid_shifts, clk, rst, en && v_q[0], v_q[1])

endmodule

// ----- rtl/core/ldik_out.sv -----
// Result stage: carriage heights from the roots, then an output register and a skid register.
// Drives the pipeline advance enable; uses ldik_pkg and the assertion header.
`include "linear_delta_inverse_kinematics_core_assert.svh"

module ldik_out #(
  parameter int COORD_BITS = 19
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  ldik_pkg::cfg_t                                      cfg,
  input  logic                                                res_valid,
  input  logic [ldik_pkg::LANES-1:0][ldik_pkg::ROOT_BITS-1:0] root,
  input  logic signed [COORD_BITS-1:0]                        z,
  input  logic                                                fail,
  output logic                                                en,
  output logic                                                out_valid,
  input  logic                                                out_stall,
  output logic signed [ldik_pkg::OUT_BITS-1:0]                carriage_one,
  output logic signed [ldik_pkg::OUT_BITS-1:0]                carriage_two,
  output logic signed [ldik_pkg::OUT_BITS-1:0]                carriage_three,
  output logic                                                out_of_workspace
);

  localparam int OB = ldik_pkg::OUT_BITS;
  localparam int RB = ldik_pkg::REG_BITS;
  localparam int HW = ((COORD_BITS > RB + 1) ? COORD_BITS : RB + 1) + 2;
  localparam int NL = ldik_pkg::LANES;

  logic [HW-1:0]         z_e;
  logic [NL-1:0][HW-1:0] ht_c;
  logic [NL-1:0][OB-1:0] res_c;

  assign z_e = {{(HW-COORD_BITS){z[COORD_BITS-1]}}, z};

  // The root covers four times the radicand, so halve it for micrometres.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ht_c[i]  = z_e + {{(HW-RB){1'b0}}, root[i][RB:1]}
                     - {{(HW-RB){1'b0}}, cfg.carriage_offset};
      res_c[i] = fail ? '0 : ht_c[i][OB-1:0];
    end
  end

  logic                  skid_valid;
  logic [NL-1:0][OB-1:0] skid_res;
  logic                  skid_fail;
  logic                  take;

  assign take = out_valid && !out_stall;
  assign en   = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        carriage_one     <= skid_res[0];
        carriage_two     <= skid_res[1];
        carriage_three   <= skid_res[2];
        out_of_workspace <= skid_fail;
      end
    end else if (res_valid) begin
      if (out_valid && !take) begin
        skid_res  <= res_c;
        skid_fail <= fail;
      end else begin
        carriage_one     <= res_c[0];
        carriage_two     <= res_c[1];
        carriage_three   <= res_c[2];
        out_of_workspace <= fail;
      end
    end
  end

  logic heights_zero;

  assign heights_zero = (carriage_one == '0) && (carriage_two == '0) && (carriage_three == '0);

  `LDIK_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `LDIK_ASSERT_NEXT(a_drain_empties, clk, rst, take && !skid_valid && !res_valid, !out_valid)
  `LDIK_ASSERT_SAME(a_unreachable_zero, clk, rst, out_valid && out_of_workspace, heights_zero)

endmodule

// ----- rtl/core/linear_delta_inverse_kinematics_core.sv -----
// Top level of the linear delta inverse kinematics core: config registers and the pipeline.
// Uses ldik_pkg, ldik_geom, ldik_isqrt and ldik_out.
//
//   channel   direction  handshake              payload
//   target    in         in_valid / in_stall    target_x, target_y, target_z
//   carriage  out        out_valid / out_stall  carriage_one..three, out_of_workspace
//   config    in         cfg_write              cfg_index, cfg_data
//
// One target is taken per cycle while in_stall is low; its result passes through 25 register
// stages: five geometry stages, nineteen square root stages and one output register.
// The square root pipeline, one root bit per stage, sets the depth.
// Reset is synchronous; it empties the pipeline and loads the default geometry.
// A skid register behind the output lets one more beat land while the output is stalled;
// in_stall rises only when that skid register is full, and then every stage holds.
module linear_delta_inverse_kinematics_core #(
  parameter int COORD_BITS = 19
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ldik_pkg::IDX_BITS-1:0]          cfg_index,
  input  logic [ldik_pkg::REG_BITS-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_BITS-1:0]           target_x,
  input  logic signed [COORD_BITS-1:0]           target_y,
  input  logic signed [COORD_BITS-1:0]           target_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ldik_pkg::OUT_BITS-1:0]   carriage_one,
  output logic signed [ldik_pkg::OUT_BITS-1:0]   carriage_two,
  output logic signed [ldik_pkg::OUT_BITS-1:0]   carriage_three,
  output logic                                   out_of_workspace
);

  localparam int TAG_BITS = COORD_BITS + 1;

  ldik_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_length      <= ldik_pkg::ARM_LENGTH_RST;
      cfg.platform_radius <= ldik_pkg::PLATFORM_RADIUS_RST;
      cfg.base_radius     <= ldik_pkg::BASE_RADIUS_RST;
      cfg.carriage_offset <= ldik_pkg::CARRIAGE_OFFSET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        ldik_pkg::REG_ARM_LENGTH:      cfg.arm_length      <= cfg_data;
        ldik_pkg::REG_PLATFORM_RADIUS: cfg.platform_radius <= cfg_data;
        ldik_pkg::REG_BASE_RADIUS:     cfg.base_radius     <= cfg_data;
        ldik_pkg::REG_CARRIAGE_OFFSET: cfg.carriage_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  logic                                                en;
  logic                                                rad_valid;
  logic [ldik_pkg::LANES-1:0][ldik_pkg::SQ_BITS-1:0]   rad;
  logic signed [COORD_BITS-1:0]                        rad_z;
  logic                                                rad_fail;
  logic                                                res_valid;
  logic [ldik_pkg::LANES-1:0][ldik_pkg::ROOT_BITS-1:0] root;
  logic [TAG_BITS-1:0]                                 res_tag;

  assign in_stall = !en;

  ldik_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (in_valid),
    .x        (target_x),
    .y        (target_y),
    .z        (target_z),
    .rad_valid(rad_valid),
    .rad      (rad),
    .rad_z    (rad_z),
    .rad_fail (rad_fail)
  );

  ldik_isqrt #(
    .TAG_BITS(TAG_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (rad_valid),
    .rad      (rad),
    .tag_in   ({rad_z, rad_fail}),
    .out_valid(res_valid),
    .root     (root),
    .tag_out  (res_tag)
  );

  ldik_out #(
    .COORD_BITS(COORD_BITS)
  ) u_out (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .root            (root),
    .z               (res_tag[TAG_BITS-1:1]),
    .fail            (res_tag[0]),
    .en              (en),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .carriage_one    (carriage_one),
    .carriage_two    (carriage_two),
    .carriage_three  (carriage_three),
    .out_of_workspace(out_of_workspace)
  );

endmodule
